@@ rtl/cca_pkg.sv @@
`timescale 1ns / 1ps
package cca_pkg;

  // Time unit limits.
  localparam logic [20:0] US_PER_SEC    = 21'd1000000;
  localparam logic [6:0]  SEC_PER_MIN   = 7'd60;
  localparam logic [7:0]  MIN_PER_HOUR  = 8'd60;
  localparam logic [5:0]  HOURS_PER_DAY = 6'd24;
  localparam logic [4:0]  MONTHS_PER_YR = 5'd12;
  localparam logic [13:0] YEAR_LAST     = 14'd9999;

  // Reciprocals for the constant divisions of the elapsed time.
  // floor(n / 15625) = (n * RECIP_15625) >> 40 for any 26-bit n.
  localparam logic [26:0] RECIP_15625 = 27'd70368745;
  // floor(n / 15) = (n * RECIP_15) >> 15 for any 11-bit n.
  localparam logic [11:0] RECIP_15    = 12'd2185;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_START_YEAR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_MONTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_DAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_HOUR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_MINUTE = 3'd4;
  localparam int unsigned CFG_DATA_W = 14;

  // Reset values of the start registers.
  localparam logic [13:0] RST_YEAR   = 14'd2016;
  localparam logic [3:0]  RST_MONTH  = 4'd1;
  localparam logic [4:0]  RST_DAY    = 5'd1;
  localparam logic [4:0]  RST_HOUR   = 5'd0;
  localparam logic [5:0]  RST_MINUTE = 6'd0;

  // Full date and time.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] micro;
  } cca_time_t;

  // Elapsed time split into whole minutes, seconds and microseconds.
  typedef struct packed {
    logic [6:0]  minutes;
    logic [5:0]  seconds;
    logic [19:0] micros;
  } cca_split_t;

  // Month length; months outside 1..12 count as 31 days.
  function automatic logic [4:0] days_in_month(input logic [13:0] year,
                                               input logic [3:0]  month);
    logic [4:0] len;
    case (month) inside
      4'd2: begin
        len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

endpackage

@@ rtl/cca_split.sv @@
`timescale 1ns / 1ps
module cca_split
  import cca_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] elapsed_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cca_split_t  out_split_o
);

  logic        v1_q, v2_q, v3_q, v4_q;
  logic        rdy1, rdy2, rdy3, rdy4;
  logic [31:0] x1_q, x2_q;
  logic [52:0] prod1_d, prod1_q;
  logic [12:0] q2_d, q2_q, q3_q;
  logic [31:0] qm2_d, qm2_q;
  logic [19:0] us3_d, us3_q;
  logic [22:0] prod3_d, prod3_q;
  logic [6:0]  min4;
  cca_split_t  split4_d, split4_q;

  // Each stage moves on when its slot is empty or its successor moves.
  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Seconds quotient: x / 1000000 = (x >> 6) / 15625.
  assign prod1_d = 53'(elapsed_us_i[31:6]) * 53'(RECIP_15625);

  assign q2_d  = prod1_q[52:40];
  assign qm2_d = 32'(q2_d * 32'(US_PER_SEC));

  assign us3_d   = 20'(x2_q - qm2_q);
  assign prod3_d = 23'(q2_q[12:2]) * 23'(RECIP_15);

  // Minutes = seconds / 60 = (seconds >> 2) / 15.
  assign min4             = prod3_q[21:15];
  assign split4_d.minutes = min4;
  assign split4_d.seconds = 6'(q3_q - 13'(min4) * 13'(SEC_PER_MIN));
  assign split4_d.micros  = us3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      x1_q    <= elapsed_us_i;
      prod1_q <= prod1_d;
    end
    if (rdy2 && v1_q) begin
      x2_q  <= x1_q;
      q2_q  <= q2_d;
      qm2_q <= qm2_d;
    end
    if (rdy3 && v2_q) begin
      us3_q   <= us3_d;
      q3_q    <= q2_q;
      prod3_q <= prod3_d;
    end
    if (rdy4 && v3_q) begin
      split4_q <= split4_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_split_o = split4_q;

endmodule

@@ rtl/cca_advance.sv @@
`timescale 1ns / 1ps
module cca_advance
  import cca_pkg::*;
(
  input  cca_time_t  cur_i,
  input  cca_split_t split_i,
  output cca_time_t  nxt_o
);

  logic [20:0] us_sum;
  logic        c_sec;
  logic [6:0]  sec_sum;
  logic        c_min;
  logic [7:0]  min_sum;
  logic [1:0]  c_hour;
  logic [5:0]  hour_sum;
  logic        c_day;
  logic [5:0]  day_inc;
  logic [4:0]  month_inc;
  logic [4:0]  dim;

  always_comb begin
    nxt_o = cur_i;

    // The split seconds and microseconds are in range, so those sums wrap at most
    // once; minutes may carry twice, since the split minutes can exceed 59.
    us_sum = 21'(cur_i.micro) + 21'(split_i.micros);
    c_sec  = (us_sum >= US_PER_SEC);
    nxt_o.micro = c_sec ? 20'(us_sum - US_PER_SEC) : us_sum[19:0];

    sec_sum = 7'(cur_i.second) + 7'(split_i.seconds) + 7'(c_sec);
    c_min   = (sec_sum >= SEC_PER_MIN);
    nxt_o.second = c_min ? 6'(sec_sum - SEC_PER_MIN) : sec_sum[5:0];

    min_sum = 8'(cur_i.minute) + 8'(split_i.minutes) + 8'(c_min);
    if (min_sum >= 8'(2 * MIN_PER_HOUR)) begin
      c_hour       = 2'd2;
      nxt_o.minute = 6'(min_sum - 8'(2 * MIN_PER_HOUR));
    end else if (min_sum >= MIN_PER_HOUR) begin
      c_hour       = 2'd1;
      nxt_o.minute = 6'(min_sum - MIN_PER_HOUR);
    end else begin
      c_hour       = 2'd0;
      nxt_o.minute = min_sum[5:0];
    end

    hour_sum = 6'(cur_i.hour) + 6'(c_hour);
    c_day    = (hour_sum >= HOURS_PER_DAY);
    nxt_o.hour = c_day ? 5'(hour_sum - HOURS_PER_DAY) : hour_sum[4:0];

    // At most one day carry per item; the month length is that of the
    // month the day is in before it advances.
    dim       = days_in_month(cur_i.year, cur_i.month);
    day_inc   = 6'(cur_i.day) + 6'd1;
    month_inc = 5'(cur_i.month) + 5'd1;
    if (c_day) begin
      if (day_inc > 6'(dim)) begin
        nxt_o.day = 5'd1;
        if (month_inc > MONTHS_PER_YR) begin
          nxt_o.month = 4'(month_inc - MONTHS_PER_YR);
          nxt_o.year  = (cur_i.year >= YEAR_LAST) ? 14'd0 : 14'(cur_i.year + 14'd1);
        end else begin
          nxt_o.month = month_inc[3:0];
        end
      end else begin
        nxt_o.day = day_inc[4:0];
      end
    end
  end

endmodule

@@ rtl/calendar_clock_advance.sv @@
`timescale 1ns / 1ps
// Calendar clock advanced by elapsed time.
//
// Input channel: each transfer on in_valid_i / in_stall_o carries elapsed_us_i,
// the microseconds gone by since the previous transfer. Output channel: one
// transfer on out_valid_o / out_stall_i per input item, giving the full date
// and time after that item has been added.
//
// An input transfer loads the first of four stages that split the elapsed time
// with reciprocal multiplies; after the fourth stage the result register adds
// the split to the stored time and carries up through hours, days, months and
// years. Throughput is one item per cycle while the receiver does not stall.
// The date and time registers are the result register, so the only loop is
// that single add-and-carry step.
//
// When the receiver stalls, the result holds and the pipeline keeps filling
// its empty stages; in_stall_o rises once all of them hold an item.
// Reset loads 2016-01-01 00:00:00.000000. A write on the configuration channel
// updates one start register and reloads the whole time from the start values,
// with seconds and microseconds at zero. Writes to other indexes are ignored.
module calendar_clock_advance
  import cca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [31:0]           elapsed_us_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [13:0]           out_year_o,
  output logic [3:0]            out_month_o,
  output logic [4:0]            out_day_o,
  output logic [4:0]            out_hour_o,
  output logic [5:0]            out_minute_o,
  output logic [5:0]            out_second_o,
  output logic [19:0]           out_microsecond_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic       split_ready;
  logic       split_valid;
  logic       in_ready;
  cca_split_t split;
  cca_time_t  now_q, now_adv;
  cca_time_t  start_d, start_q;
  logic       start_wr;
  logic       res_ready;
  logic       res_load;
  logic       out_valid_q;

  cca_split u_split (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready),
    .elapsed_us_i (elapsed_us_i),
    .out_valid_o  (split_valid),
    .out_ready_i  (split_ready),
    .out_split_o  (split)
  );

  cca_advance u_advance (
    .cur_i   (now_q),
    .split_i (split),
    .nxt_o   (now_adv)
  );

  assign in_stall_o = !in_ready;

  // The result register takes a new item when it is empty or its result
  // is leaving in this cycle.
  assign res_ready   = !out_valid_q || !out_stall_i;
  assign res_load    = split_valid && res_ready;
  assign split_ready = res_ready;

  // Configuration writes are always taken. Only the start fields of the
  // struct are used; second and micro stay zero.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    start_d  = start_q;
    start_wr = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_START_YEAR: begin
          start_d.year = cfg_data_i[13:0];
          start_wr     = 1'b1;
        end
        REG_START_MONTH: begin
          start_d.month = cfg_data_i[3:0];
          start_wr      = 1'b1;
        end
        REG_START_DAY: begin
          start_d.day = cfg_data_i[4:0];
          start_wr    = 1'b1;
        end
        REG_START_HOUR: begin
          start_d.hour = cfg_data_i[4:0];
          start_wr     = 1'b1;
        end
        REG_START_MINUTE: begin
          start_d.minute = cfg_data_i[5:0];
          start_wr       = 1'b1;
        end
        default: begin
          start_wr = 1'b0;
        end
      endcase
    end
    start_d.second = 6'd0;
    start_d.micro  = 20'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '{year: RST_YEAR, month: RST_MONTH, day: RST_DAY, hour: RST_HOUR,
                       minute: RST_MINUTE, second: 6'd0, micro: 20'd0};
      now_q       <= '{year: RST_YEAR, month: RST_MONTH, day: RST_DAY, hour: RST_HOUR,
                       minute: RST_MINUTE, second: 6'd0, micro: 20'd0};
      out_valid_q <= 1'b0;
    end else begin
      if (start_wr) begin
        start_q <= start_d;
        now_q   <= start_d;
      end else if (res_load) begin
        now_q <= now_adv;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_year_o        = now_q.year;
  assign out_month_o       = now_q.month;
  assign out_day_o         = now_q.day;
  assign out_hour_o        = now_q.hour;
  assign out_minute_o      = now_q.minute;
  assign out_second_o      = now_q.second;
  assign out_microsecond_o = now_q.micro;

endmodule
